FILE: rtl/core/lrh_pkg.sv
// Shared types and constants for the largest-rectangle histogram block.
`timescale 1ns / 1ps

package lrh_pkg;

  localparam int MAX_BARS_DEF    = 4096;
  localparam int HEIGHT_BITS_DEF = 32;

  localparam int IN_HEIGHT_W = 32;
  localparam int AREA_OUT_W  = 44;
  localparam logic [AREA_OUT_W-1:0] AREA_MAX = {AREA_OUT_W{1'b1}};

  // Request queue between the front and the stack engine.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [IN_HEIGHT_W-1:0] bar_height;
    logic                   is_last;
  } lrh_in_t;

  typedef struct packed {
    logic [AREA_OUT_W-1:0] max_area;
    logic                  overflow;
  } lrh_out_t;

  // Classified request: skip marks a bar past the per-histogram limit.
  typedef struct packed {
    logic [IN_HEIGHT_W-1:0] bar_height;
    logic                   is_last;
    logic                   skip;
  } lrh_item_t;

  typedef struct packed {
    logic      valid;
    lrh_item_t item;
  } lrh_queue_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BAR,
    S_LOAD,
    S_FLUSH,
    S_FLUSH_LOAD,
    S_DRAIN,
    S_DONE
  } lrh_state_t;

endpackage

FILE: rtl/core/lrh_front.sv
// Front end: accepts bars, tags those past the bar limit, and queues them.
`timescale 1ns / 1ps

module lrh_front #(
  parameter int MAX_BARS = lrh_pkg::MAX_BARS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               bar_valid,
  output logic               bar_stall,
  input  lrh_pkg::lrh_in_t   bar,
  output lrh_pkg::lrh_queue_t queue,
  input  logic               take
);
  import lrh_pkg::*;

  localparam int POS_W = $clog2(MAX_BARS + 1);

  lrh_item_t           q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     q_count;
  logic [POS_W-1:0]    bar_count;
  logic                push;
  logic                pop;
  logic                skip;

  assign bar_stall = (q_count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign push      = bar_valid && !bar_stall;
  assign pop       = take && queue.valid;
  assign skip      = (bar_count == POS_W'(MAX_BARS));

  assign queue.valid = (q_count != '0);
  assign queue.item  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= '{bar_height: bar.bar_height, is_last: bar.is_last, skip: skip};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      q_count   <= '0;
      bar_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
        if (bar.is_last) begin
          bar_count <= '0;
        end else if (!skip) begin
          bar_count <= bar_count + 1'b1;
        end
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        q_count <= q_count + 1'b1;
      end else if (pop && !push) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/lrh_back.sv
// Stack engine: monotonic stack in RAM, area pipeline, running max, result register.
`timescale 1ns / 1ps

module lrh_back #(
  parameter int MAX_BARS    = lrh_pkg::MAX_BARS_DEF,
  parameter int HEIGHT_BITS = lrh_pkg::HEIGHT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  lrh_pkg::lrh_queue_t queue,
  output logic                take,
  output logic                result_valid,
  input  logic                result_stall,
  output lrh_pkg::lrh_out_t   result
);
  import lrh_pkg::*;

  localparam int POS_W  = $clog2(MAX_BARS + 1);
  localparam int IDX_W  = $clog2(MAX_BARS);
  localparam int ENT_W  = POS_W + HEIGHT_BITS;
  localparam int HL     = (HEIGHT_BITS + 1) / 2;
  localparam int HH     = HEIGHT_BITS - HL;
  localparam int AREA_W = POS_W + HEIGHT_BITS;
  localparam int HX_W   = (HEIGHT_BITS > IN_HEIGHT_W) ? HEIGHT_BITS : IN_HEIGHT_W;
  localparam int EXT_W  = (AREA_W > AREA_OUT_W) ? AREA_W : AREA_OUT_W;

  lrh_state_t state;
  lrh_state_t state_next;

  // Entries below the top of stack; the top lives in top_start/top_h.
  logic [ENT_W-1:0]       stack_mem [MAX_BARS];

  logic [POS_W-1:0]       depth;
  logic [POS_W-1:0]       pos;
  logic                   ovf;
  logic [POS_W-1:0]       top_start;
  logic [HEIGHT_BITS-1:0] top_h;
  logic [HEIGHT_BITS-1:0] cur_h;
  logic                   cur_last;
  logic [POS_W-1:0]       cur_start;
  logic [POS_W-1:0]       rd_start;
  logic [HEIGHT_BITS-1:0] rd_h;

  logic                   s1_valid;
  logic [POS_W-1:0]       s1_w;
  logic [HEIGHT_BITS-1:0] s1_h;
  logic                   s2_valid;
  logic [POS_W+HL-1:0]    s2_lo;
  logic [POS_W+HH-1:0]    s2_hi;
  logic [AREA_W-1:0]      best;

  logic                   res_valid;
  logic [AREA_OUT_W-1:0]  res_area;
  logic                   res_ovf;

  logic [HX_W-1:0]        hx;
  logic [HEIGHT_BITS-1:0] item_h;
  logic [POS_W-1:0]       src_start;
  logic [HEIGHT_BITS-1:0] src_h;
  logic                   src_hi;
  logic                   from_top;
  logic                   more;
  logic                   pop_bar;
  logic                   do_pop;
  logic                   push;
  logic [POS_W-1:0]       push_start;
  logic                   mem_we;
  logic                   rd_en;
  logic [POS_W-1:0]       depth_m1;
  logic [POS_W-1:0]       depth_m2;
  logic                   res_load;
  logic [POS_W+HL-1:0]    lo_prod;
  logic [POS_W+HH-1:0]    hi_prod;
  logic [AREA_W-1:0]      area;
  logic [EXT_W-1:0]       best_ext;

  assign hx     = HX_W'(queue.item.bar_height);
  assign item_h = hx[HEIGHT_BITS-1:0];

  assign from_top  = (state == S_BAR) || (state == S_FLUSH);
  assign src_start = from_top ? top_start : rd_start;
  assign src_h     = from_top ? top_h : rd_h;
  assign src_hi    = (src_h > cur_h);
  assign more      = (depth > POS_W'(1));
  assign depth_m1  = depth - POS_W'(1);
  assign depth_m2  = depth - POS_W'(2);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (queue.valid) begin
          if (!queue.item.skip) begin
            state_next = S_BAR;
          end else if (queue.item.is_last) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_BAR, S_LOAD: begin
        if (pop_bar && more) begin
          state_next = S_LOAD;
        end else begin
          state_next = cur_last ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (depth != '0 && more) begin
          state_next = S_FLUSH_LOAD;
        end else begin
          state_next = S_DRAIN;
        end
      end
      S_FLUSH_LOAD: begin
        state_next = more ? S_FLUSH_LOAD : S_DRAIN;
      end
      S_DRAIN: begin
        if (!s1_valid && !s2_valid) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!res_valid || !result_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ------------------------------------------------------------- control outputs
  always_comb begin
    take       = 1'b0;
    pop_bar    = 1'b0;
    do_pop     = 1'b0;
    push       = 1'b0;
    push_start = pos;
    mem_we     = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        take = queue.valid;
      end
      S_BAR: begin
        pop_bar = (depth != '0) && src_hi;
        do_pop  = pop_bar;
        // a pop that empties the stack pushes the new bar in the same cycle
        push       = !pop_bar || !more;
        push_start = pop_bar ? src_start : pos;
        mem_we     = !pop_bar && (depth != '0);
      end
      S_LOAD: begin
        pop_bar    = src_hi;
        do_pop     = pop_bar;
        push       = !pop_bar || !more;
        push_start = pop_bar ? src_start : cur_start;
      end
      S_FLUSH: begin
        do_pop = (depth != '0);
      end
      S_FLUSH_LOAD: begin
        do_pop = 1'b1;
      end
      S_DRAIN: begin
      end
      S_DONE: begin
        res_load = !res_valid || !result_stall;
      end
      default: begin
      end
    endcase
  end

  assign rd_en = do_pop && more;

  // -------------------------------------------------------------------- stack RAM
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[depth_m1[IDX_W-1:0]] <= {top_start, top_h};
    end
    if (rd_en) begin
      {rd_start, rd_h} <= stack_mem[depth_m2[IDX_W-1:0]];
    end
  end

  // ------------------------------------------------------------------ stack control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      depth <= '0;
      pos   <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      if (take && queue.item.skip) begin
        ovf <= 1'b1;
      end
      if (do_pop && !push) begin
        depth <= depth - POS_W'(1);
      end else if (push && !do_pop) begin
        depth <= depth + POS_W'(1);
      end
      if (push) begin
        pos <= pos + POS_W'(1);
      end
      if (res_load) begin
        depth <= '0;
        pos   <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_h    <= item_h;
      cur_last <= queue.item.is_last;
    end
    if (do_pop) begin
      cur_start <= src_start;
    end
    if (push) begin
      top_start <= push_start;
      top_h     <= cur_h;
    end
  end

  // ------------------------------------------------------------------ area pipeline
  // width * height split in two partial products, summed one stage later
  assign lo_prod = {{HL{1'b0}}, s1_w} * {{POS_W{1'b0}}, s1_h[HL-1:0]};
  assign hi_prod = {{HH{1'b0}}, s1_w} * {{POS_W{1'b0}}, s1_h[HEIGHT_BITS-1:HL]};
  assign area    = AREA_W'(s2_lo) + (AREA_W'(s2_hi) << HL);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      best     <= '0;
    end else begin
      s1_valid <= do_pop;
      s2_valid <= s1_valid;
      if (res_load) begin
        best <= '0;
      end else if (s2_valid && (area > best)) begin
        best <= area;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      s1_w <= (pos >= src_start) ? (pos - src_start) : '0;
      s1_h <= src_h;
    end
    if (s1_valid) begin
      s2_lo <= lo_prod;
      s2_hi <= hi_prod;
    end
  end

  // ---------------------------------------------------------------- result register
  assign best_ext = EXT_W'(best);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!result_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_area <= (best_ext > EXT_W'(AREA_MAX)) ? AREA_MAX : best_ext[AREA_OUT_W-1:0];
      res_ovf  <= ovf;
    end
  end

  assign result_valid    = res_valid;
  assign result.max_area = res_area;
  assign result.overflow = res_ovf;

  // -------------------------------------------------------------------- assertions
  a_drained_at_done: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> !s1_valid && !s2_valid)
    else $error("result issued with area pipeline busy");

  a_depth_le_pos: assert property (@(posedge clk) disable iff (rst)
    depth <= pos)
    else $error("stack deeper than bar count");

  a_note_from_pop: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(state) == S_BAR || $past(state) == S_LOAD ||
                 $past(state) == S_FLUSH || $past(state) == S_FLUSH_LOAD)
    else $error("area request outside a pop state");

  a_result_clears: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_DONE && depth == '0 && pos == '0)
    else $error("state not cleared with result");

endmodule

FILE: rtl/core/largest_rectangle_histogram.sv
// Top level of the largest-rectangle-in-histogram block.
`timescale 1ns / 1ps

// Bars stream in on the bar channel, one request per bar; the bar flagged
// is_last closes the histogram and produces one result with the largest
// rectangle area and an overflow flag (set if more than MAX_BARS bars came;
// extra bars are dropped). Only the low HEIGHT_BITS bits of a height count.
// A four-entry request queue decouples input from the stack engine, which
// takes the next bar only once it has done all pops of the current one;
// after the first pop of a bar, each pop waits on the registered read of
// the stack RAM, and each bar is popped at most once. After the last bar the
// flush pops every stacked entry, drains the two-stage multiplier and loads
// the result register. Areas beyond 44 bits saturate. No clearing pass is
// needed after reset.

module largest_rectangle_histogram #(
  parameter int MAX_BARS    = lrh_pkg::MAX_BARS_DEF,
  parameter int HEIGHT_BITS = lrh_pkg::HEIGHT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              bar_valid,
  output logic              bar_stall,
  input  lrh_pkg::lrh_in_t  bar,
  output logic              result_valid,
  input  logic              result_stall,
  output lrh_pkg::lrh_out_t result
);
  import lrh_pkg::*;

  lrh_queue_t queue;
  logic       take;

  lrh_front #(
    .MAX_BARS (MAX_BARS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .bar_valid (bar_valid),
    .bar_stall (bar_stall),
    .bar       (bar),
    .queue     (queue),
    .take      (take)
  );

  lrh_back #(
    .MAX_BARS    (MAX_BARS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .queue        (queue),
    .take         (take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

FILE: sim/largest_rectangle_histogram_test.sv
// Self-checking testbench for the largest-rectangle histogram block.
`timescale 1ns / 1ps

module largest_rectangle_histogram_test;
  import lrh_pkg::*;

  localparam int BAR_LIMIT = MAX_BARS_DEF;
  localparam int HEIGHT_W  = HEIGHT_BITS_DEF;
  localparam logic [63:0] HEIGHT_MASK = (64'd1 << HEIGHT_W) - 64'd1;
  localparam int RANDOM_ITEMS = 1000;
  localparam int TALL_BARS    = 256;
  localparam int HOLD_AT  = 1500;   // receiver cycle at which the long hold-off starts
  localparam int HOLD_LEN = 500;
  localparam int TAIL_CYCLES = 40;

  // Tracks the running monotonic stack and queues one expected area per histogram.
  class histogram_scoreboard;
    int unsigned run_start [BAR_LIMIT];
    logic [63:0] run_height [BAR_LIMIT];
    int unsigned depth;
    int unsigned position;
    logic [63:0] best;
    bit          over;
    lrh_out_t    expected_q [$];
    int unsigned errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      depth    = 0;
      position = 0;
      best     = '0;
      over     = 1'b0;
    endfunction

    function void keep_area(int unsigned at, int unsigned from, logic [63:0] h);
      logic [63:0] width;
      logic [63:0] area;
      width = (at >= from) ? 64'(at - from) : 64'd0;
      area  = width * h;
      if (area > best) best = area;
    endfunction

    function void note_bar(lrh_in_t req);
      logic [63:0] h;
      int unsigned start;
      lrh_out_t    exp_res;
      h = {32'b0, req.bar_height} & HEIGHT_MASK;
      if (position < BAR_LIMIT) begin
        start = position;
        while (depth > 0 && run_height[depth-1] > h) begin
          depth--;
          start = run_start[depth];
          keep_area(position, start, run_height[depth]);
        end
        if (depth < BAR_LIMIT) begin
          run_start[depth]  = start;
          run_height[depth] = h;
          depth++;
        end
        position++;
      end else begin
        over = 1'b1;
      end
      if (req.is_last) begin
        // flush: sentinel below every height pops the whole stack
        while (depth > 0) begin
          depth--;
          keep_area(position, run_start[depth], run_height[depth]);
        end
        exp_res.max_area = (best > 64'(AREA_MAX)) ? AREA_MAX : best[AREA_OUT_W-1:0];
        exp_res.overflow = over;
        expected_q.push_back(exp_res);
        clear();
      end
    endfunction

    task report(string msg);
      if (errors < 100) $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(lrh_out_t got);
      lrh_out_t exp_res;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result area=%0d overflow=%0b",
                         got.max_area, got.overflow));
      end else begin
        exp_res = expected_q.pop_front();
        if (got.max_area !== exp_res.max_area)
          report($sformatf("max_area got %0d expected %0d", got.max_area, exp_res.max_area));
        if (got.overflow !== exp_res.overflow)
          report($sformatf("overflow got %0b expected %0b", got.overflow, exp_res.overflow));
      end
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic     clk;
  logic     rst = 1'b1;
  logic     bar_valid = 1'b0;
  logic     bar_stall;
  lrh_in_t  bar = '0;
  logic     result_valid;
  logic     result_stall = 1'b0;
  lrh_out_t result;

  histogram_scoreboard sb = new();

  int unsigned burst_left = 0;
  logic [31:0] hist [$];

  largest_rectangle_histogram uut (
    .clk          (clk),
    .rst          (rst),
    .bar_valid    (bar_valid),
    .bar_stall    (bar_stall),
    .bar          (bar),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && bar_valid && !bar_stall) sb.note_bar(bar);
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  // Receiver: rotating stall modes plus one long hold-off.
  initial begin : receiver
    int unsigned cyc;
    int unsigned mode;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      mode = (cyc / 64) % 4;
      if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_LEN) result_stall <= 1'b1;
      else begin
        case (mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= ($urandom_range(0, 3) != 0);
          default: result_stall <= ((cyc % 5) < 2);
        endcase
      end
    end
  end

  task automatic send_bar(input logic [31:0] h, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        bar_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    bar_valid <= 1'b1;
    bar.bar_height <= h;
    bar.is_last    <= last;
    @(posedge clk);
    while (bar_stall) @(posedge clk);
  endtask

  task automatic send_hist();
    for (int i = 0; i < hist.size(); i++) send_bar(hist[i], i == hist.size() - 1);
  endtask

  task automatic wait_drained();
    bar_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random histogram: mostly short, varied height profiles.
  task automatic build_random_hist();
    int unsigned len;
    int unsigned pick;
    int unsigned profile;
    logic [31:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 80) len = $urandom_range(1, 16);
    else if (pick < 95) len = $urandom_range(17, 64);
    else len = $urandom_range(65, 200);
    profile = $urandom_range(0, 5);
    v = $urandom();
    hist = {};
    for (int i = 0; i < len; i++) begin
      case (profile)
        0: v = $urandom_range(0, 7);
        1: v = $urandom();
        2: v = v + $urandom_range(0, 3);
        3: v = v - $urandom_range(0, 3);
        4: if ($urandom_range(0, 4) == 0) v = $urandom();
        default: begin
          case ($urandom_range(0, 2))
            0: v = '0;
            1: v = '1;
            default: v = $urandom();
          endcase
        end
      endcase
      hist.push_back(v);
    end
  endtask

  initial begin : stimulus
    int unsigned sent;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single bars at both height extremes
    hist = {32'd0};
    send_hist();
    hist = {32'hFFFF_FFFF};
    send_hist();
    // equal heights push without popping
    hist = {32'd3, 32'd3, 32'd3};
    send_hist();
    hist = {32'd2, 32'd1, 32'd5, 32'd6, 32'd2, 32'd3};
    send_hist();
    // zero in the middle pops everything
    hist = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF};
    send_hist();
    hist = {32'd1, 32'd2, 32'd3, 32'd4};
    send_hist();
    hist = {32'd4, 32'd3, 32'd2, 32'd1};
    send_hist();
    hist = {32'hAAAA_AAAA, 32'h5555_5555};
    send_hist();
    wait_drained();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      build_random_hist();
      sent += hist.size();
      send_hist();
    end
    wait_drained();

    // long run of tallest bars: wide, high area
    hist = {};
    for (int i = 0; i < TALL_BARS; i++) hist.push_back(32'hFFFF_FFFF);
    send_hist();
    // next histogram must start clean
    hist = {32'd7, 32'd9};
    send_hist();
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("largest_rectangle_histogram_test: clean");
    end else begin
      $display("largest_rectangle_histogram_test: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("largest_rectangle_histogram_test: errors");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/lrh_pkg.sv
rtl/core/lrh_front.sv
rtl/core/lrh_back.sv
rtl/core/largest_rectangle_histogram.sv
sim/largest_rectangle_histogram_test.sv
